### hw/rtl/tte_pkg.sv
// ----------------------------------------------------------------------------
// tte_pkg
// shared widths, byte class bounds, skip codes, register indexes and result method codes
// for the text token estimator
// ----------------------------------------------------------------------------
package tte_pkg;

  // fixed field widths
  localparam int BYTE_W     = 8;
  localparam int TOKEN_W    = 19;
  localparam int TOTAL_W    = 48;
  localparam int REQ_W      = 32;
  localparam int SKIP_W     = 2;

  // register port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_CJK_ENABLE = 1'b0;

  // byte class bounds
  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD3_LO    = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_HI    = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_LO    = 8'hF0;
  localparam logic [BYTE_W-1:0] DIGIT_LO    = 8'h30;
  localparam logic [BYTE_W-1:0] DIGIT_HI    = 8'h39;
  localparam logic [BYTE_W-1:0] UPPER_LO    = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_HI    = 8'h5A;
  localparam logic [BYTE_W-1:0] LOWER_LO    = 8'h61;
  localparam logic [BYTE_W-1:0] LOWER_HI    = 8'h7A;

  // continuation bytes still to be passed over by the multibyte estimate
  localparam logic [SKIP_W-1:0] SKIP_NONE  = 2'd0;
  localparam logic [SKIP_W-1:0] SKIP_ONE   = 2'd1;
  localparam logic [SKIP_W-1:0] SKIP_TWO   = 2'd2;
  localparam logic [SKIP_W-1:0] SKIP_THREE = 2'd3;

  typedef enum logic [1:0] {
    METHOD_MULTIBYTE = 2'd0,
    METHOD_WORD      = 2'd1,
    METHOD_LENGTH    = 2'd2
  } method_t;

endpackage

### hw/rtl/text_token_estimator.sv
// ----------------------------------------------------------------------------
// text_token_estimator
// streaming token count estimate for a text string, one byte per item
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one nonzero text byte per item, in_last_byte marks the final byte
//   out_* : one result item per finished string (estimate, method used,
//           wrapping running total of estimates, wrapping string count)
//   psel/penable/...: register port, cjk_enable at byte address 0
// throughput: one byte per cycle while the snapshot stage can take each last
//   byte, set by the single counter update stage that every byte passes through
// result path: after its last byte is accepted, a result reaches out_valid
//   through the input register, counter/snapshot stage and result register
// stall: while a result waits on out_ready, one finished string parks in
//   the snapshot stage and bytes of the following string keep streaming;
//   only a second last byte waits until the snapshot stage frees up
// reset: synchronous, active low; clears the counters, running total,
//   string count and cjk_enable, and drops all valids
// bytes past MAX_TEXT_LENGTH in one string are ignored by the counters, but
//   a last byte among them still finishes the string
// ----------------------------------------------------------------------------
module text_token_estimator
  import tte_pkg::*;
#(
  parameter int MAX_TEXT_LENGTH = 131072
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_text_byte,
  input  logic                  in_last_byte,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TOKEN_W-1:0]    out_token_estimate,
  output logic [1:0]            out_method_used,
  output logic [TOTAL_W-1:0]    out_running_total,
  output logic [REQ_W-1:0]      out_request_total,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // counter widths follow the longest string that is counted
  localparam int CNT_W  = $clog2(MAX_TEXT_LENGTH + 1);
  localparam int EST_W  = CNT_W + 1;              // estimates reach about 2*len
  localparam int CMP_W  = CNT_W + 2;              // room for 3*len
  localparam int WIDE_W = (CMP_W > TOKEN_W) ? CMP_W : TOKEN_W;

  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_TEXT_LENGTH);

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------
  logic                 cjk_enable_r;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cjk_enable_r <= 1'b0;
    end else if (cfg_wr && (cfg_idx == REG_CJK_ENABLE)) begin
      cjk_enable_r <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_idx == REG_CJK_ENABLE) begin
      prdata[0] = cjk_enable_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage handshakes: result register, snapshot stage, input register
  // ---------------------------------------------------------------------------
  logic in_valid_r;
  logic in_last_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic fin_valid_r;
  logic out_valid_r;

  logic out_load;   // snapshot moves into the result register
  logic fin_free;   // snapshot stage can take a finished string
  logic byte_go;    // registered byte is folded into the counters

  assign out_load = fin_valid_r && (!out_valid_r || out_ready);
  assign fin_free = !fin_valid_r || out_load;
  assign byte_go  = in_valid_r && (!in_last_r || fin_free);
  assign in_ready = !in_valid_r || byte_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_text_byte;
      in_last_r <= in_last_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // per-string counters
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]  cnt_r,    cnt_nxt;
  logic [CNT_W-1:0]  lead_r,   lead_nxt;
  logic [CNT_W-1:0]  letter_r, letter_nxt;
  logic [EST_W-1:0]  mb_r,     mb_nxt;
  logic [EST_W-1:0]  word_r,   word_nxt;
  logic [SKIP_W-1:0] skip_r,   skip_nxt;
  logic              inside_r, inside_nxt;

  logic take;
  logic is_lead3;
  logic is_letter;
  logic is_word;
  logic [EST_W-1:0] word_final;

  assign take      = cnt_r < MAX_LEN;
  assign is_lead3  = (in_byte_r >= LEAD3_LO) && (in_byte_r <= LEAD3_HI);
  assign is_letter = ((in_byte_r >= UPPER_LO) && (in_byte_r <= UPPER_HI)) ||
                     ((in_byte_r >= LOWER_LO) && (in_byte_r <= LOWER_HI));
  // high bytes count as word bytes, unsigned compare
  assign is_word   = is_letter || (in_byte_r >= ASCII_LIMIT) ||
                     ((in_byte_r >= DIGIT_LO) && (in_byte_r <= DIGIT_HI));

  // counter values with the registered byte folded in
  always_comb begin
    cnt_nxt    = cnt_r;
    lead_nxt   = lead_r;
    letter_nxt = letter_r;
    mb_nxt     = mb_r;
    word_nxt   = word_r;
    skip_nxt   = skip_r;
    inside_nxt = inside_r;
    if (take) begin
      cnt_nxt    = cnt_r + 1'b1;
      lead_nxt   = lead_r + CNT_W'(is_lead3);
      letter_nxt = letter_r + CNT_W'(is_letter);

      // multibyte estimate: ascii counts 1, a lead counts 2, its tail is skipped
      if (skip_r != SKIP_NONE) begin
        skip_nxt = skip_r - 1'b1;
      end else if (in_byte_r < ASCII_LIMIT) begin
        mb_nxt = mb_r + EST_W'(1);
      end else begin
        mb_nxt = mb_r + EST_W'(2);
        if (in_byte_r < LEAD3_LO) begin
          skip_nxt = SKIP_ONE;
        end else if (in_byte_r < LEAD4_LO) begin
          skip_nxt = SKIP_TWO;
        end else begin
          skip_nxt = SKIP_THREE;
        end
      end

      // word estimate: each separator counts 1, closing a word adds 1 more
      if (is_word) begin
        inside_nxt = 1'b1;
      end else begin
        word_nxt   = word_r + EST_W'(1) + EST_W'(inside_r);
        inside_nxt = 1'b0;
      end
    end
  end

  // an open word at the end of the string counts once more
  assign word_final = word_nxt + EST_W'(inside_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      lead_r   <= '0;
      letter_r <= '0;
      mb_r     <= '0;
      word_r   <= '0;
      skip_r   <= SKIP_NONE;
      inside_r <= 1'b0;
    end else if (byte_go) begin
      if (in_last_r) begin
        // string done: start the next one from zero
        cnt_r    <= '0;
        lead_r   <= '0;
        letter_r <= '0;
        mb_r     <= '0;
        word_r   <= '0;
        skip_r   <= SKIP_NONE;
        inside_r <= 1'b0;
      end else begin
        cnt_r    <= cnt_nxt;
        lead_r   <= lead_nxt;
        letter_r <= letter_nxt;
        mb_r     <= mb_nxt;
        word_r   <= word_nxt;
        skip_r   <= skip_nxt;
        inside_r <= inside_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // snapshot of a finished string
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] fin_len_r;
  logic [CNT_W-1:0] fin_lead_r;
  logic [CNT_W-1:0] fin_letter_r;
  logic [EST_W-1:0] fin_mb_r;
  logic [EST_W-1:0] fin_word_r;
  logic             fin_valid_nxt;

  always_comb begin
    fin_valid_nxt = fin_valid_r;
    if (byte_go && in_last_r) begin
      fin_valid_nxt = 1'b1;
    end else if (out_load) begin
      fin_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else begin
      fin_valid_r <= fin_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_go && in_last_r) begin
      fin_len_r    <= cnt_nxt;
      fin_lead_r   <= lead_nxt;
      fin_letter_r <= letter_nxt;
      fin_mb_r     <= mb_nxt;
      fin_word_r   <= word_final;
    end
  end

  // ---------------------------------------------------------------------------
  // estimate choice and result register
  // lead > floor(len/3) is the same as 3*lead > len, likewise for letters
  // ---------------------------------------------------------------------------
  logic [CMP_W-1:0]   len_ext;
  logic [CMP_W-1:0]   lead_x3;
  logic [CMP_W-1:0]   letter_x2;
  logic [CMP_W-1:0]   len_x3;
  logic [WIDE_W-1:0]  est_wide;
  logic [TOKEN_W-1:0] est_tok;
  method_t            method_sel;

  logic [TOKEN_W-1:0] out_token_r;
  method_t            out_method_r;
  logic [TOTAL_W-1:0] sum_r;
  logic [REQ_W-1:0]   req_r;
  logic               out_valid_nxt;

  assign len_ext   = CMP_W'(fin_len_r);
  assign lead_x3   = CMP_W'(fin_lead_r) + (CMP_W'(fin_lead_r) << 1);
  assign letter_x2 = CMP_W'(fin_letter_r) << 1;
  assign len_x3    = len_ext + (len_ext << 1);

  always_comb begin
    if (cjk_enable_r && (lead_x3 > len_ext)) begin
      est_wide   = WIDE_W'(fin_mb_r);
      method_sel = METHOD_MULTIBYTE;
    end else if (letter_x2 > len_ext) begin
      est_wide   = WIDE_W'(fin_word_r);
      method_sel = METHOD_WORD;
    end else begin
      est_wide   = WIDE_W'(len_x3 >> 2);
      method_sel = METHOD_LENGTH;
    end
  end

  assign est_tok = est_wide[TOKEN_W-1:0];

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      req_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (out_load) begin
        sum_r <= sum_r + TOTAL_W'(est_tok);
        req_r <= req_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_token_r  <= est_tok;
      out_method_r <= method_sel;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_token_estimate = out_token_r;
  assign out_method_used    = out_method_r;
  assign out_running_total  = sum_r;
  assign out_request_total  = req_r;

`ifndef SYNTHESIS
  // a parked snapshot is never dropped before it reaches the result register
  a_fin_held: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_valid_r && !out_load) |=> fin_valid_r)
    else $error("finished string lost from snapshot stage");

  // the string count moves by one per result
  a_req_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (req_r == $past(req_r) + 1'b1))
    else $error("string count did not step by one");

  // the byte counter stops at the length limit
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_LEN)
    else $error("byte count past length limit");

  // counters start clean after a last byte
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_go && in_last_r) |=> (cnt_r == '0 && skip_r == SKIP_NONE && !inside_r))
    else $error("string state not cleared after last byte");
`endif

endmodule

### sim/tb_text_token_estimator.sv
// ----------------------------------------------------------------------------
// tb_text_token_estimator
// self-checking bench for the streaming token count estimator: text bytes go
// in one item at a time, finished strings are checked field by field against
// an in-bench estimator, the cjk check register is toggled between phases
// ----------------------------------------------------------------------------
module tb_text_token_estimator;
  import tte_pkg::*;

  // length cap of one string, also handed to the block
  localparam int MAX_LEN       = 131072;
  // long output stall used to back the block up into its input
  localparam int HOLD_CYCLES   = 120;
  // cycles with no handshake at all before the run is declared hung
  localparam int QUIET_LIMIT   = 2000;
  // extra idle time after the last result is taken
  localparam int SETTLE_CYCLES = 6;
  localparam int DIR_ROWS      = 25;

  // register map: one register per word
  localparam logic [APB_ADDR_W-1:0] CJK_ADDR   = APB_ADDR_W'(4 * int'(REG_CJK_ENABLE));
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = APB_ADDR_W'(4 * (int'(REG_CJK_ENABLE) + 1));

  // flavors of random text
  typedef enum int {
    STYLE_PROSE,
    STYLE_CJK,
    STYLE_MIXED,
    STYLE_LEADS,
    STYLE_NOISE
  } text_style_t;

  // one finished string as the block should report it
  typedef struct {
    logic [TOKEN_W-1:0] est;
    method_t            how;
    logic [TOTAL_W-1:0] total;
    logic [REQ_W-1:0]   reqs;
  } estimate_t;

  // directed row: a byte, its last flag, and optionally a typed-in result
  typedef struct packed {
    logic [BYTE_W-1:0]  b;
    logic               last;
    logic               typed;
    logic [TOKEN_W-1:0] est;
    method_t            how;
  } text_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  in_valid;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_text_byte;
  logic                  in_last_byte;

  logic                  out_valid;
  logic                  out_ready;
  logic [TOKEN_W-1:0]    out_token_estimate;
  logic [1:0]            out_method_used;
  logic [TOTAL_W-1:0]    out_running_total;
  logic [REQ_W-1:0]      out_request_total;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // typed-in expectation rides along with the payload it belongs to
  logic                  row_typed;
  logic [TOKEN_W-1:0]    row_est;
  method_t               row_how;

  always #1 clk = ~clk;

  text_token_estimator #(
    .MAX_TEXT_LENGTH(MAX_LEN)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_text_byte       (in_text_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_token_estimate (out_token_estimate),
    .out_method_used    (out_method_used),
    .out_running_total  (out_running_total),
    .out_request_total  (out_request_total),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // --------------------------------------------------------------------------
  // estimator state, mirrors what the block holds per string and overall
  // --------------------------------------------------------------------------
  logic               cjk_mode    = 1'b0;
  logic [17:0]        str_len     = '0;
  logic [17:0]        cjk_leads   = '0;
  logic [17:0]        alpha_cnt   = '0;
  logic [TOKEN_W-1:0] mb_tokens   = '0;
  logic [SKIP_W-1:0]  skip_left   = SKIP_NONE;
  logic [TOKEN_W-1:0] word_tokens = '0;
  logic               in_word     = 1'b0;
  logic [TOTAL_W-1:0] token_acc   = '0;
  logic [REQ_W-1:0]   string_acc  = '0;

  // results still owed by the block, oldest first
  estimate_t estimates_due[$];

  // run bookkeeping
  int mismatches  = 0;
  int results_ok  = 0;
  int bytes_sent  = 0;
  int cfg_writes  = 0;
  int method_hits [3];
  int quiet_count = 0;

  // idling switches and the stall request for the receiver
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_req   = 0;

  logic [BYTE_W-1:0] text_buf[$];
  logic [BYTE_W-1:0] punct_set [8];
  text_row_t         dir_rows [DIR_ROWS];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s after %0d good results: got %0d, want %0d",
             what, results_ok, got, want);
    mismatches++;
  endtask

  function automatic logic is_alpha(input logic [BYTE_W-1:0] b);
    return (b >= UPPER_LO && b <= UPPER_HI) || (b >= LOWER_LO && b <= LOWER_HI);
  endfunction

  // fold one accepted byte into the estimator, queue a result on the last one
  task automatic tally_byte(input logic [BYTE_W-1:0] b, input logic last,
                            input logic typed, input logic [TOKEN_W-1:0] t_est,
                            input method_t t_how);
    estimate_t    r;
    logic [TOKEN_W-1:0] word_total;
    logic         wordish;
    // bytes past the cap touch no counter
    if (int'(str_len) < MAX_LEN) begin
      str_len = str_len + 1'b1;
      if (b >= LEAD3_LO && b <= LEAD3_HI) cjk_leads = cjk_leads + 1'b1;
      if (is_alpha(b)) alpha_cnt = alpha_cnt + 1'b1;

      // multibyte estimate: ascii 1, a lead 2, its continuation bytes nothing
      if (skip_left != SKIP_NONE) begin
        skip_left = skip_left - 1'b1;
      end else if (b < ASCII_LIMIT) begin
        mb_tokens = mb_tokens + 1'b1;
      end else begin
        mb_tokens = mb_tokens + 2'd2;
        if (b < LEAD3_LO) skip_left = SKIP_ONE;
        else if (b < LEAD4_LO) skip_left = SKIP_TWO;
        else skip_left = SKIP_THREE;
      end

      // word estimate: high bytes count as word bytes too
      wordish = is_alpha(b) || (b >= DIGIT_LO && b <= DIGIT_HI) || b >= ASCII_LIMIT;
      if (wordish) begin
        in_word = 1'b1;
      end else begin
        word_tokens = word_tokens + 1'b1 + in_word;
        in_word = 1'b0;
      end
    end

    if (last) begin
      word_total = word_tokens + in_word;
      if (cjk_mode && cjk_leads > str_len / 3) begin
        r.est = mb_tokens;
        r.how = METHOD_MULTIBYTE;
      end else if (alpha_cnt > str_len / 2) begin
        r.est = word_total;
        r.how = METHOD_WORD;
      end else begin
        r.est = TOKEN_W'((32'(str_len) * 3) / 4);
        r.how = METHOD_LENGTH;
      end
      // directed rows carry a hand-worked answer instead
      if (typed) begin
        r.est = t_est;
        r.how = t_how;
      end
      token_acc  = token_acc + r.est;
      string_acc = string_acc + 1'b1;
      r.total = token_acc;
      r.reqs  = string_acc;
      estimates_due.push_back(r);

      str_len     = '0;
      cjk_leads   = '0;
      alpha_cnt   = '0;
      mb_tokens   = '0;
      skip_left   = SKIP_NONE;
      word_tokens = '0;
      in_word     = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // monitor: register writes, accepted bytes, accepted results, hang watch
  // everything is sampled at the rising edge, before the block updates
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    estimate_t want;
    logic      moved;
    moved = 1'b0;
    if (rst_n) begin
      if (psel && penable && pready) begin
        moved = 1'b1;
        // only bit 0 of the value lands, other addresses do nothing
        if (pwrite && paddr == CJK_ADDR) cjk_mode = pwdata[0];
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        tally_byte(in_text_byte, in_last_byte, row_typed, row_est, row_how);
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (estimates_due.size() == 0) begin
          report_mismatch("result with nothing pending", out_token_estimate, 0);
        end else begin
          want = estimates_due.pop_front();
          if (out_token_estimate !== want.est)
            report_mismatch("token_estimate", out_token_estimate, want.est);
          if (out_method_used !== want.how)
            report_mismatch("method_used", out_method_used, want.how);
          if (out_running_total !== want.total)
            report_mismatch("running_total", out_running_total, want.total);
          if (out_request_total !== want.reqs)
            report_mismatch("request_total", out_request_total, want.reqs);
          results_ok++;
          method_hits[want.how]++;
        end
      end
    end
    // hang watch: any handshake restarts the count
    if (moved) quiet_count = 0;
    else quiet_count++;
    if (quiet_count >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results still owed",
               QUIET_LIMIT, estimates_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stall bursts, plus one long hold on request
  // --------------------------------------------------------------------------
  initial begin
    int hold_seen;
    hold_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        // long hold so the snapshot stage fills and input backs up
        hold_seen = hold_req;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------

  // offer one byte and hold it until taken, then maybe go quiet a while
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
                           input logic typed, input logic [TOKEN_W-1:0] t_est,
                           input method_t t_how);
    in_valid     <= 1'b1;
    in_text_byte <= b;
    in_last_byte <= last;
    row_typed    <= typed;
    row_est      <= t_est;
    row_how      <= t_how;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (tx_idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // one register access; an idle gap after it keeps psel edges apart
  task automatic reg_xfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                          input logic [APB_DATA_W-1:0] wdata,
                          output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write the cjk check with junk in the upper bits, then read it back
  task automatic set_cjk(input logic v);
    logic [APB_DATA_W-1:0] rd;
    reg_xfer(1'b1, CJK_ADDR, (APB_DATA_W'($urandom()) & ~APB_DATA_W'(1)) | APB_DATA_W'(v), rd);
    cfg_writes++;
    reg_xfer(1'b0, CJK_ADDR, '0, rd);
    if (rd !== APB_DATA_W'(v)) report_mismatch("cjk_enable readback", rd, v);
  endtask

  // stop offering, wait out every owed result and the pipeline behind it
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (estimates_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] rand_letter();
    if ($urandom_range(0, 1) == 0) return BYTE_W'($urandom_range(UPPER_LO, UPPER_HI));
    return BYTE_W'($urandom_range(LOWER_LO, LOWER_HI));
  endfunction

  // well-formed utf-8 sequence of n bytes with random content
  task automatic push_seq(input int n);
    case (n)
      2:       text_buf.push_back(BYTE_W'($urandom_range(8'hC2, 8'hDF)));
      3:       text_buf.push_back(BYTE_W'($urandom_range(LEAD3_LO, LEAD3_HI)));
      default: text_buf.push_back(BYTE_W'($urandom_range(LEAD4_LO, 8'hF4)));
    endcase
    repeat (n - 1) text_buf.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
  endtask

  // build a string of the given flavor; trimming may cut a sequence short
  task automatic fill_text(input text_style_t style, input int len);
    int r;
    text_buf.delete();
    while (text_buf.size() < len) begin
      r = $urandom_range(0, 99);
      case (style)
        STYLE_PROSE: begin
          if (r < 70) text_buf.push_back(rand_letter());
          else if (r < 80) text_buf.push_back(BYTE_W'($urandom_range(DIGIT_LO, DIGIT_HI)));
          else text_buf.push_back(punct_set[$urandom_range(0, 7)]);
        end
        STYLE_CJK: begin
          if (r < 75) push_seq(3);
          else if (r < 85) text_buf.push_back(rand_letter());
          else text_buf.push_back(punct_set[$urandom_range(0, 7)]);
        end
        STYLE_MIXED: begin
          if (r < 20) text_buf.push_back(rand_letter());
          else if (r < 30) text_buf.push_back(punct_set[$urandom_range(0, 7)]);
          else if (r < 55) push_seq(2);
          else if (r < 85) push_seq(3);
          else push_seq(4);
        end
        // broken text: stray leads everywhere, lead count can beat len/3
        STYLE_LEADS: begin
          if (r < 60) text_buf.push_back(BYTE_W'($urandom_range(LEAD3_LO, LEAD3_HI)));
          else text_buf.push_back(BYTE_W'($urandom_range(1, 255)));
        end
        default: text_buf.push_back(BYTE_W'($urandom_range(1, 255)));
      endcase
    end
    while (text_buf.size() > len) text_buf.delete(text_buf.size() - 1);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++)
      send_byte(text_buf[i], i == text_buf.size() - 1, 1'b0, '0, METHOD_LENGTH);
  endtask

  // random strings until the byte budget is spent, mostly well-formed text
  task automatic run_random(input int budget);
    int          sent;
    int          r;
    int          len;
    text_style_t style;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 9);
      if (r < 3) style = STYLE_PROSE;
      else if (r < 6) style = STYLE_CJK;
      else if (r < 8) style = STYLE_MIXED;
      else if (r == 8) style = STYLE_LEADS;
      else style = STYLE_NOISE;
      // short strings mostly, now and then a longer one
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
      fill_text(style, len);
      send_text();
      sent += text_buf.size();
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [APB_DATA_W-1:0] rd;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_text_byte <= '0;
    in_last_byte <= 1'b0;
    row_typed    <= 1'b0;
    row_est      <= '0;
    row_how      <= METHOD_LENGTH;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;

    punct_set = '{8'h20, 8'h2C, 8'h2E, 8'h21, 8'h3F, 8'h2D, 8'h0A, 8'h27};

    // directed strings, run with the cjk check on
    // typed answers where the result is obvious, the rest go to the estimator
    dir_rows = '{
      // single letter: word estimate of one open word
      '{8'h41, 1'b1, 1'b1, 19'd1, METHOD_WORD},
      // top and bottom byte values, and a zero byte: length estimate of 0
      '{8'hFF, 1'b1, 1'b1, 19'd0, METHOD_LENGTH},
      '{8'h01, 1'b1, 1'b1, 19'd0, METHOD_LENGTH},
      '{8'h00, 1'b1, 1'b1, 19'd0, METHOD_LENGTH},
      // lone three-byte leads, skip runs past the end of the string
      '{8'hE4, 1'b1, 1'b1, 19'd2, METHOD_MULTIBYTE},
      '{8'hEF, 1'b1, 1'b1, 19'd2, METHOD_MULTIBYTE},
      '{8'hE0, 1'b1, 1'b1, 19'd2, METHOD_MULTIBYTE},
      // skip left over from the lead above must not leak into this string
      '{8'hE5, 1'b0, 1'b0, 19'd0, METHOD_LENGTH},
      '{8'h41, 1'b1, 1'b1, 19'd2, METHOD_MULTIBYTE},
      // one full three-byte character then a dangling lead
      '{8'hE4, 1'b0, 1'b0, 19'd0, METHOD_LENGTH},
      '{8'hB8, 1'b0, 1'b0, 19'd0, METHOD_LENGTH},
      '{8'hAD, 1'b0, 1'b0, 19'd0, METHOD_LENGTH},
      '{8'hE5, 1'b1, 1'b0, 19'd0, METHOD_LENGTH},
      // four-byte lead swallows a three-byte lead as continuation
      '{8'hF0, 1'b0, 1'b0, 19'd0, METHOD_LENGTH},
      '{8'h9F, 1'b0, 1'b0, 19'd0, METHOD_LENGTH},
      '{8'hE4, 1'b1, 1'b0, 19'd0, METHOD_LENGTH},
      // "hi, yo": punctuation after a word counts double, open word at end
      '{8'h68, 1'b0, 1'b0, 19'd0, METHOD_LENGTH},
      '{8'h69, 1'b0, 1'b0, 19'd0, METHOD_LENGTH},
      '{8'h2C, 1'b0, 1'b0, 19'd0, METHOD_LENGTH},
      '{8'h20, 1'b0, 1'b0, 19'd0, METHOD_LENGTH},
      '{8'h79, 1'b0, 1'b0, 19'd0, METHOD_LENGTH},
      '{8'h6F, 1'b1, 1'b1, 19'd4, METHOD_WORD},
      // digit and a bare 0x80 are word bytes, not letters
      '{8'h39, 1'b0, 1'b0, 19'd0, METHOD_LENGTH},
      '{8'h80, 1'b0, 1'b0, 19'd0, METHOD_LENGTH},
      '{8'h2E, 1'b1, 1'b0, 19'd0, METHOD_LENGTH}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // register extremes; a write elsewhere in the map must leave it alone
    set_cjk(1'b1);
    reg_xfer(1'b1, SPARE_ADDR, '1, rd);
    reg_xfer(1'b0, CJK_ADDR, '0, rd);
    if (rd !== APB_DATA_W'(1)) report_mismatch("cjk_enable after spare write", rd, 1);

    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed,
                dir_rows[i].est, dir_rows[i].how);
    settle();

    // random phases, cjk check flipping between them
    for (int p = 0; p < 4; p++) begin
      set_cjk(p[0]);
      if (p == 2) begin
        // hold the output while short strings keep coming, input must stall
        hold_req++;
        repeat (10) begin
          fill_text(STYLE_CJK, $urandom_range(1, 2));
          send_text();
        end
      end
      run_random(100);
      settle();
    end

    // closing stretch at full rate on both sides
    set_cjk(1'b1);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random(70);
    settle();

    $display("checked %0d strings from %0d bytes: %0d multibyte, %0d word, %0d length",
             results_ok, bytes_sent, method_hits[METHOD_MULTIBYTE],
             method_hits[METHOD_WORD], method_hits[METHOD_LENGTH]);
    $display("cjk check written %0d times, one output hold of %0d cycles",
             cfg_writes, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/tte_pkg.sv
hw/rtl/text_token_estimator.sv
sim/tb_text_token_estimator.sv
